[src/ffa_pkg.sv]
`timescale 1ns / 1ps
package ffa_pkg;

  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned SIZE_W  = 17;
  localparam int unsigned NEED_W  = 18;
  localparam int unsigned BYTES_W = 20;
  localparam int unsigned DIVD_W  = 21;
  localparam int unsigned DEPTH   = 65536;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_OOM     = 2'd1,
    ST_ZERO    = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_F_CHK,
    S_L_WALK,
    S_L_NX,
    S_L_P,
    S_DIV,
    S_A_PREV,
    S_A_CHK,
    S_A_MARK,
    S_RESP
  } ctl_e;

  typedef struct packed {
    logic              mark;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] next;
  } hdr_t;

endpackage

[src/ffa_if.sv]
`timescale 1ns / 1ps
interface ffa_req_if;
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic [ffa_pkg::BYTES_W-1:0]      size_bytes;
  logic [ffa_pkg::ADDR_W-1:0]       free_address;

  modport source (output valid, req_type, size_bytes, free_address, input ready);
  modport sink (input valid, req_type, size_bytes, free_address, output ready);
endinterface

interface ffa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ffa_pkg::ADDR_W-1:0]  block_address;
  logic [1:0]                  status;

  modport source (output valid, block_address, status, input ready);
  modport sink (input valid, block_address, status, output ready);
endinterface

[src/first_fit_free_list_allocator_core.sv]
`timescale 1ns / 1ps
// First-fit free-list allocator over a 65536-unit header memory.
// req_i carries allocate (size in bytes) or free (payload unit address)
// requests; rsp_o returns one response per request: granted payload
// address and a status (done, out of memory, zero-size, free ignored).
// Requests are handled one at a time. A free walks the free list block
// by block to find its place. An allocate converts bytes to units
// with a reciprocal multiply, then visits free-list blocks from the
// rover, plus a free-style insert when the break has to grow. Each
// list step reads or writes the single header memory, which sets
// the pace.
// After reset the block sweeps the header memory once to clear it,
// with req_i.ready low. The list then holds only the
// sentinel at unit 0, the rover is 0 and the break is 1.
// A finished response waits in an output register; a new request is
// taken while it waits, and a second response holds until rsp_o is read.
module first_fit_free_list_allocator_core #(
  parameter int unsigned ARENA_UNITS = 65536,
  parameter int unsigned GROW_UNITS  = 4096,
  parameter int unsigned UNIT_BYTES  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ffa_req_if.sink   req_i,
  ffa_rsp_if.source rsp_o
);

  localparam int unsigned AW = ffa_pkg::ADDR_W;
  localparam int unsigned SW = ffa_pkg::SIZE_W;
  localparam int unsigned NW = ffa_pkg::NEED_W;
  localparam int unsigned ArenaTopU = (ARENA_UNITS < 65536) ? ARENA_UNITS : 65536;
  localparam logic [NW-1:0] ArenaTop = NW'(ArenaTopU);
  localparam logic [NW-1:0] GrowN    = NW'(GROW_UNITS);

  ffa_pkg::ctl_e    ctl_q, ctl_d;
  ffa_pkg::hdr_t    rdata, wdata, pw_q, pw_d, prevw_q, prevw_d, wqd_q, wqd_d, pnew;
  logic             re, we;
  logic [AW-1:0]    raddr, waddr;
  logic [AW-1:0]    clr_q, clr_d;
  logic [AW-1:0]    rover_q, rover_d, p_q, p_d, prev_q, prev_d, bp_q, bp_d;
  logic [AW-1:0]    bnx_q, bnx_d, wqa_q, wqa_d, nx;
  logic [SW-1:0]    bsz_q, bsz_d, bsz_n, rem;
  logic [SW-1:0]    brk_q, brk_d;
  logic [NW-1:0]    need_q, need_d, nu;
  logic             free_mode_q, free_mode_d;
  logic [AW-1:0]    res_addr_q, res_addr_d;
  ffa_pkg::status_e res_st_q, res_st_d;
  logic             out_valid_q, out_valid_d;
  logic [AW-1:0]    out_addr_q, out_addr_d;
  ffa_pkg::status_e out_st_q, out_st_d;
  logic             div_start, div_done;
  logic [ffa_pkg::DIVD_W-1:0] div_quot, dividend;
  logic             accept, stop, merge;

  ffa_ram #(
    .Width($bits(ffa_pkg::hdr_t)),
    .Depth(ffa_pkg::DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  ffa_udiv #(
    .Divisor(UNIT_BYTES)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(dividend),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign dividend = {1'b0, req_i.size_bytes} + ffa_pkg::DIVD_W'(UNIT_BYTES - 1);
  assign req_i.ready = (ctl_q == ffa_pkg::S_IDLE);
  assign accept = req_i.valid && req_i.ready;

  always_comb begin
    ctl_d       = ctl_q;
    clr_d       = clr_q;
    rover_d     = rover_q;
    brk_d       = brk_q;
    p_d         = p_q;
    pw_d        = pw_q;
    prev_d      = prev_q;
    prevw_d     = prevw_q;
    bp_d        = bp_q;
    bsz_d       = bsz_q;
    bnx_d       = bnx_q;
    need_d      = need_q;
    wqa_d       = wqa_q;
    wqd_d       = wqd_q;
    free_mode_d = free_mode_q;
    res_addr_d  = res_addr_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_addr_d  = out_addr_q;
    out_st_d    = out_st_q;
    re          = 1'b0;
    raddr       = '0;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    div_start   = 1'b0;
    nx          = rdata.next;
    stop        = 1'b0;
    merge       = 1'b0;
    bsz_n       = bsz_q;
    pnew        = pw_q;
    rem         = rdata.size - need_q[SW-1:0];
    nu          = (need_q < GrowN) ? GrowN : need_q;

    case (ctl_q)
      ffa_pkg::S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + 1'b1;
        if (&clr_q) begin
          ctl_d = ffa_pkg::S_IDLE;
        end
      end
      ffa_pkg::S_IDLE: begin
        if (accept) begin
          res_addr_d = '0;
          if (req_i.req_type == ffa_pkg::REQ_FREE) begin
            bp_d = req_i.free_address - 1'b1;
            if (req_i.free_address == '0 ||
                {1'b0, req_i.free_address - 1'b1} >= brk_q) begin
              res_st_d = ffa_pkg::ST_IGNORED;
              ctl_d    = ffa_pkg::S_RESP;
            end else begin
              re    = 1'b1;
              raddr = req_i.free_address - 1'b1;
              ctl_d = ffa_pkg::S_F_CHK;
            end
          end else if (req_i.size_bytes == '0) begin
            res_st_d = ffa_pkg::ST_ZERO;
            ctl_d    = ffa_pkg::S_RESP;
          end else begin
            div_start = 1'b1;
            ctl_d     = ffa_pkg::S_DIV;
          end
        end
      end
      ffa_pkg::S_F_CHK: begin
        if (!rdata.mark) begin
          res_st_d = ffa_pkg::ST_IGNORED;
          ctl_d    = ffa_pkg::S_RESP;
        end else begin
          bsz_d       = rdata.size;
          free_mode_d = 1'b1;
          p_d         = rover_q;
          re          = 1'b1;
          raddr       = rover_q;
          ctl_d       = ffa_pkg::S_L_WALK;
        end
      end
      ffa_pkg::S_L_WALK: begin
        // find p with p < bp < next, or the wrap point of the list
        stop = (bp_q > p_q && bp_q < nx) ||
               (p_q >= nx && (bp_q > p_q || bp_q < nx));
        pw_d  = rdata;
        re    = 1'b1;
        raddr = nx;
        if (stop) begin
          ctl_d = ffa_pkg::S_L_NX;
        end else begin
          p_d = nx;
        end
      end
      ffa_pkg::S_L_NX: begin
        // merge with the upper neighbor, write the freed header unmarked
        merge = ({2'b0, bp_q} + {1'b0, bsz_q}) == {2'b0, pw_q.next};
        bsz_n = merge ? bsz_q + rdata.size : bsz_q;
        bnx_d = merge ? rdata.next : pw_q.next;
        bsz_d = bsz_n;
        we    = 1'b1;
        waddr = bp_q;
        wdata = '{mark: 1'b0, size: bsz_n, next: bnx_d};
        ctl_d = ffa_pkg::S_L_P;
      end
      ffa_pkg::S_L_P: begin
        // merge with the lower neighbor
        merge = ({2'b0, p_q} + {1'b0, pw_q.size}) == {2'b0, bp_q};
        pnew  = merge ? '{mark: pw_q.mark, size: pw_q.size + bsz_q, next: bnx_q}
                      : '{mark: pw_q.mark, size: pw_q.size, next: bp_q};
        we      = 1'b1;
        waddr   = p_q;
        wdata   = pnew;
        rover_d = p_q;
        if (free_mode_q) begin
          res_st_d = ffa_pkg::ST_DONE;
          ctl_d    = ffa_pkg::S_RESP;
        end else begin
          prev_d  = p_q;
          prevw_d = pnew;
          p_d     = pnew.next;
          re      = 1'b1;
          raddr   = pnew.next;
          ctl_d   = ffa_pkg::S_A_CHK;
        end
      end
      ffa_pkg::S_DIV: begin
        if (div_done) begin
          need_d = div_quot[NW-1:0] + 1'b1;
          re     = 1'b1;
          raddr  = rover_q;
          ctl_d  = ffa_pkg::S_A_PREV;
        end
      end
      ffa_pkg::S_A_PREV: begin
        prev_d  = rover_q;
        prevw_d = rdata;
        p_d     = rdata.next;
        re      = 1'b1;
        raddr   = rdata.next;
        ctl_d   = ffa_pkg::S_A_CHK;
      end
      ffa_pkg::S_A_CHK: begin
        if ({1'b0, rdata.size} >= need_q) begin
          we      = 1'b1;
          rover_d = prev_q;
          if ({1'b0, rdata.size} == need_q) begin
            waddr      = prev_q;
            wdata      = '{mark: prevw_q.mark, size: prevw_q.size, next: rdata.next};
            wqa_d      = p_q;
            wqd_d      = '{mark: 1'b1, size: rdata.size, next: rdata.next};
            res_addr_d = p_q + 1'b1;
          end else begin
            // carve the tail off a larger block
            waddr      = p_q;
            wdata      = '{mark: rdata.mark, size: rem, next: rdata.next};
            wqa_d      = p_q + rem[AW-1:0];
            wqd_d      = '{mark: 1'b1, size: need_q[SW-1:0], next: rdata.next};
            res_addr_d = p_q + rem[AW-1:0] + 1'b1;
          end
          ctl_d = ffa_pkg::S_A_MARK;
        end else if (p_q == rover_q) begin
          if ({1'b0, brk_q} >= ArenaTop || nu > ArenaTop - {1'b0, brk_q}) begin
            res_st_d = ffa_pkg::ST_OOM;
            ctl_d    = ffa_pkg::S_RESP;
          end else begin
            // grow the break and insert the new chunk as a free block
            bp_d        = brk_q[AW-1:0];
            bsz_d       = nu[SW-1:0];
            brk_d       = brk_q + nu[SW-1:0];
            free_mode_d = 1'b0;
            p_d         = rover_q;
            re          = 1'b1;
            raddr       = rover_q;
            ctl_d       = ffa_pkg::S_L_WALK;
          end
        end else begin
          prev_d  = p_q;
          prevw_d = rdata;
          p_d     = rdata.next;
          re      = 1'b1;
          raddr   = rdata.next;
        end
      end
      ffa_pkg::S_A_MARK: begin
        we       = 1'b1;
        waddr    = wqa_q;
        wdata    = wqd_q;
        res_st_d = ffa_pkg::ST_DONE;
        ctl_d    = ffa_pkg::S_RESP;
      end
      ffa_pkg::S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_addr_d  = res_addr_q;
          out_st_d    = res_st_q;
          ctl_d       = ffa_pkg::S_IDLE;
        end
      end
      default: begin
        ctl_d = ffa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= ffa_pkg::S_CLEAR;
      clr_q       <= '0;
      rover_q     <= '0;
      brk_q       <= SW'(1);
      out_valid_q <= 1'b0;
      free_mode_q <= 1'b0;
    end else begin
      ctl_q       <= ctl_d;
      clr_q       <= clr_d;
      rover_q     <= rover_d;
      brk_q       <= brk_d;
      out_valid_q <= out_valid_d;
      free_mode_q <= free_mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q        <= p_d;
    pw_q       <= pw_d;
    prev_q     <= prev_d;
    prevw_q    <= prevw_d;
    bp_q       <= bp_d;
    bsz_q      <= bsz_d;
    bnx_q      <= bnx_d;
    need_q     <= need_d;
    wqa_q      <= wqa_d;
    wqd_q      <= wqd_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    out_addr_q <= out_addr_d;
    out_st_q   <= out_st_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.block_address = out_addr_q;
  assign rsp_o.status        = out_st_q;

endmodule

[src/ffa_ram.sv]
`timescale 1ns / 1ps
module ffa_ram #(
  parameter int Width = 34,
  parameter int Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/ffa_udiv.sv]
`timescale 1ns / 1ps
module ffa_udiv #(
  parameter int unsigned Divisor = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ffa_pkg::DIVD_W-1:0]  dividend_i,
  output logic                        done_o,
  output logic [ffa_pkg::DIVD_W-1:0]  quot_o
);

  // Divide by a constant through a reciprocal multiply:
  // quot = (x * ceil(2^Shift / Divisor)) >> Shift, exact for every DIVD_W-bit x
  // when Shift = DIVD_W + clog2(Divisor).
  localparam int unsigned DivW  = ffa_pkg::DIVD_W;
  localparam int unsigned Shift = DivW + $clog2(Divisor);
  localparam int unsigned MulW  = DivW + 2;
  localparam int unsigned ProdW = DivW + MulW;
  localparam longint unsigned RecipL =
      ((64'd1 << Shift) + 64'(Divisor) - 64'd1) / 64'(Divisor);
  localparam logic [MulW-1:0] Recip = MulW'(RecipL);

  logic [ProdW-1:0] prod;
  logic [DivW-1:0]  quo_q;
  logic             done_q;

  assign prod = dividend_i * Recip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= DivW'(prod >> Shift);
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
